// ----- design/abld_pkg.sv -----
// Shared types, constants and helpers for the anchor box and landmark decoder.
// No dependencies.
package abld_pkg;

  localparam int unsigned ANCHOR_COUNT_DEF = 2;
  localparam int unsigned GRID_BITS_DEF   = 10;
  localparam int unsigned EXP_DEPTH_DEF   = 256;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 120;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR0   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR1   = 8'd3;

  localparam logic KIND_BOX      = 1'b0;
  localparam logic KIND_LANDMARK = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [9:0]         col;
    logic [9:0]         row;
    logic               anc;
    logic [15:0]        score;
    logic signed [15:0] d1;
    logic signed [15:0] d2;
    logic signed [15:0] d3;
    logic signed [15:0] d4;
    logic signed [17:0] wid;
    logic signed [17:0] hgt;
    logic signed [23:0] cenx;
    logic signed [23:0] ceny;
  } job_t;

  function automatic logic [19:0] sat20(input logic signed [39:0] v);
    logic [19:0] r;
    if (v > 40'sd524287) r = 20'h7FFFF;
    else if (v < -40'sd524288) r = 20'h80000;
    else r = v[19:0];
    return r;
  endfunction

endpackage

// ----- design/abld_queue.sv -----
// Short job queue between the front and back ends.
// Depends on abld_pkg for the job type.
module abld_queue #(
  parameter int unsigned DEPTH = abld_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  abld_pkg::job_t   job_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output abld_pkg::job_t   job_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  abld_pkg::job_t  mem_q [DEPTH];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

endmodule

// ----- design/abld_front.sv -----
// Front end: configuration registers, item acceptance, score test and anchor geometry.
// Depends on abld_pkg.
module abld_front #(
  parameter int unsigned ANCHOR_COUNT = abld_pkg::ANCHOR_COUNT_DEF,
  parameter int unsigned GRID_BITS    = abld_pkg::GRID_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [abld_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [abld_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                in_kind_i,
  input  logic [abld_pkg::IN_DATA_W-1:0]      in_data_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output abld_pkg::job_t                      job_o
);
  localparam logic [9:0] GMASK = (GRID_BITS >= 10) ? 10'h3FF : 10'((1 << GRID_BITS) - 1);

  logic [15:0] thr_q;
  logic [8:0]  stride_q;
  logic [63:0] anc0_q, anc1_q;

  logic               keep_q;
  logic signed [17:0] wid_q, hgt_q;
  logic signed [23:0] cenx_q, ceny_q;
  logic [20:0]        held_q;

  logic        accept, keep, sel_raw, sel;
  logic [9:0]  col, row;
  logic [15:0] score;
  logic [63:0] a;
  logic signed [15:0] ax1, ay1, ax2, ay2;
  logic signed [17:0] wid, hgt;
  logic [18:0] sxu, syu;
  logic signed [24:0] cx25, cy25;
  logic signed [16:0] sumx, sumy;
  logic signed [23:0] cenx, ceny;

  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    logic signed [23:0] r;
    if (v[24] != v[23]) r = v[24] ? 24'sh800000 : 24'sh7FFFFF;
    else r = v[23:0];
    return r;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    col     = in_data_i[9:0] & GMASK;
    row     = in_data_i[19:10] & GMASK;
    sel_raw = in_data_i[20];
    sel     = (32'(sel_raw) >= ANCHOR_COUNT) ? 1'(ANCHOR_COUNT - 1) : sel_raw;
    score   = in_data_i[36:21];
    keep    = (score >= thr_q);
    a       = sel ? anc1_q : anc0_q;
    ax1     = a[15:0];
    ay1     = a[31:16];
    ax2     = a[47:32];
    ay2     = a[63:48];
    wid     = 18'(ax2) - 18'(ax1) + 18'sd16;
    hgt     = 18'(ay2) - 18'(ay1) + 18'sd16;
    sxu     = 19'(col) * 19'(stride_q);
    syu     = 19'(row) * 19'(stride_q);
    sumx    = 17'(ax1) + 17'(ax2);
    sumy    = 17'(ay1) + 17'(ay2);
    cx25    = 25'($signed(sumx[16:1])) + $signed({2'b0, sxu, 4'b0});
    cy25    = 25'($signed(sumy[16:1])) + $signed({2'b0, syu, 4'b0});
    cenx    = sat24(cx25);
    ceny    = sat24(cy25);
  end

  always_comb begin
    job_o.kind  = in_kind_i;
    job_o.d1    = in_data_i[52:37];
    job_o.d2    = in_data_i[68:53];
    job_o.d3    = in_data_i[84:69];
    job_o.d4    = in_data_i[100:85];
    if (in_kind_i == abld_pkg::KIND_BOX) begin
      job_o.col   = col;
      job_o.row   = row;
      job_o.anc   = sel;
      job_o.score = score;
      job_o.wid   = wid;
      job_o.hgt   = hgt;
      job_o.cenx  = cenx;
      job_o.ceny  = ceny;
      push_o      = accept && keep;
    end else begin
      job_o.col   = held_q[9:0];
      job_o.row   = held_q[19:10];
      job_o.anc   = held_q[20];
      job_o.score = '0;
      job_o.wid   = wid_q;
      job_o.hgt   = hgt_q;
      job_o.cenx  = cenx_q;
      job_o.ceny  = ceny_q;
      push_o      = accept && keep_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= 16'd32768;
      stride_q <= 9'd16;
      anc0_q   <= '0;
      anc1_q   <= '0;
      keep_q   <= 1'b0;
      wid_q    <= '0;
      hgt_q    <= '0;
      cenx_q   <= '0;
      ceny_q   <= '0;
      held_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          abld_pkg::CFG_THRESHOLD: thr_q    <= cfg_data_i[15:0];
          abld_pkg::CFG_STRIDE:    stride_q <= cfg_data_i[8:0];
          abld_pkg::CFG_ANCHOR0:   anc0_q   <= cfg_data_i;
          abld_pkg::CFG_ANCHOR1:   anc1_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept && in_kind_i == abld_pkg::KIND_BOX) begin
        keep_q <= keep;
        if (keep) begin
          wid_q  <= wid;
          hgt_q  <= hgt;
          cenx_q <= cenx;
          ceny_q <= ceny;
          held_q <= {sel, row, col};
        end
      end
    end
  end

endmodule

// ----- design/abld_back.sv -----
// Back end: exp lookup, shared multiplier sequencer and output register.
// Depends on abld_pkg.
module abld_back #(
  parameter int unsigned EXP_TABLE_DEPTH = abld_pkg::EXP_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_empty_i,
  input  abld_pkg::job_t                       job_i,
  output logic                                 pop_o,
  output logic                                 m_tvalid_o,
  input  logic                                 m_tready_i,
  output logic                                 m_tuser_o,
  output logic [abld_pkg::OUT_DATA_W-1:0]      m_tdata_o
);
  localparam int unsigned QW = $clog2(EXP_TABLE_DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_EXP, ST_MUL, ST_DONE} state_e;

  typedef struct packed {
    logic signed [4:0] k;
    logic [QW-1:0]     q;
  } exp_idx_t;

  logic [17:0] exp_lut [EXP_TABLE_DEPTH];

  for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_lut
    localparam longint T  = (longint'(i) * 65536) / EXP_TABLE_DEPTH;
    localparam longint P1 = 14821 + (T * 5179) / 65536;
    localparam longint P2 = 45560 + (T * P1) / 65536;
    localparam longint P3 = 65536 + (T * P2) / 65536;
    assign exp_lut[i] = 18'(P3);
  end

  function automatic exp_idx_t exp_split(input logic signed [15:0] d);
    logic signed [29:0] m;
    logic signed [16:0] y;
    logic [21:0]        fq;
    exp_idx_t           r;
    m   = 30'(d) * 30'sd5909;
    y   = m[28:12];
    fq  = 22'(y[11:0]) * 22'(EXP_TABLE_DEPTH);
    r.k = y[16:12];
    r.q = fq[12 +: QW];
    return r;
  endfunction

  state_e             state_q;
  abld_pkg::job_t     job_q;
  logic [17:0]        pw_q, ph_q;
  logic signed [4:0]  kw_q, kh_q;
  logic [2:0]         cnt_q;
  logic signed [37:0] prod_q;
  logic signed [26:0] cx_q, cy_q;
  logic signed [33:0] hw_q, hh_q;
  logic               m_valid_q, m_user_q;
  logic [abld_pkg::OUT_DATA_W-1:0] m_data_q;

  exp_idx_t           ew, eh;
  logic [2:0]         nmul;
  logic signed [18:0] ma, mb;
  logic signed [25:0] rnd12;
  logic signed [4:0]  kcur;
  logic [4:0]         sh;
  logic signed [38:0] pw_full, hfull;
  logic signed [33:0] half;
  logic               out_free;
  logic [19:0]        xa, ya, xb, yb;

  assign ew       = exp_split(job_q.d3);
  assign eh       = exp_split(job_q.d4);
  assign nmul     = (job_q.kind == abld_pkg::KIND_LANDMARK) ? 3'd2 : 3'd4;
  assign out_free = !m_valid_q || m_tready_i;
  assign pop_o    = (state_q == ST_IDLE) && !q_empty_i;

  always_comb begin
    case (cnt_q)
      3'd0:    begin ma = 19'(job_q.d1);  mb = 19'(job_q.wid); end
      3'd1:    begin ma = 19'(job_q.d2);  mb = 19'(job_q.hgt); end
      3'd2:    begin ma = 19'(job_q.wid); mb = $signed({1'b0, pw_q}); end
      default: begin ma = 19'(job_q.hgt); mb = $signed({1'b0, ph_q}); end
    endcase
    rnd12   = 26'((39'(prod_q) + 39'sd2048) >>> 12);
    kcur    = (cnt_q == 3'd3) ? kw_q : kh_q;
    sh      = 5'(6'sd16 - 6'(kcur));
    pw_full = (39'(prod_q) + (39'sd1 <<< (sh - 5'd1))) >>> sh;
    hfull   = (pw_full - 39'sd16 + 39'sd1) >>> 1;
    half    = 34'(hfull);
  end

  always_comb begin
    if (job_q.kind == abld_pkg::KIND_LANDMARK) begin
      xa = abld_pkg::sat20(40'(cx_q));
      ya = abld_pkg::sat20(40'(cy_q));
      xb = '0;
      yb = '0;
    end else begin
      xa = abld_pkg::sat20(40'(cx_q) - 40'(hw_q));
      ya = abld_pkg::sat20(40'(cy_q) - 40'(hh_q));
      xb = abld_pkg::sat20(40'(cx_q) + 40'(hw_q));
      yb = abld_pkg::sat20(40'(cy_q) + 40'(hh_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_DONE && out_free) m_valid_q <= 1'b1;
      else if (m_tready_i) m_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) state_q <= ST_EXP;
        end
        ST_EXP: begin
          cnt_q   <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (cnt_q == nmul) state_q <= ST_DONE;
          else cnt_q <= cnt_q + 3'd1;
        end
        ST_DONE: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    if (state_q == ST_EXP) begin
      pw_q <= exp_lut[ew.q];
      ph_q <= exp_lut[eh.q];
      kw_q <= ew.k;
      kh_q <= eh.k;
    end
    if (state_q == ST_MUL) begin
      if (cnt_q < nmul) prod_q <= ma * mb;
      case (cnt_q)
        3'd1: cx_q <= 27'(job_q.cenx) + 27'(rnd12);
        3'd2: cy_q <= 27'(job_q.ceny) + 27'(rnd12);
        3'd3: hw_q <= half;
        3'd4: hh_q <= half;
        default: ;
      endcase
    end
    if (state_q == ST_DONE && out_free) begin
      m_user_q <= job_q.kind;
      m_data_q <= {3'b0, yb, xb, ya, xa, job_q.score, job_q.anc, job_q.row, job_q.col};
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tuser_o  = m_user_q;
  assign m_tdata_o  = m_data_q;

endmodule

// ----- design/anchor_box_landmark_decode_core.sv -----
// Anchor box and landmark decoder.
// Input stream: tuser = func (0 box, 1 landmark), tdata holds the candidate fields.
// Output stream: tuser = out_kind (0 box, 1 landmark point), tdata the decoded result.
// Configuration: write enable, index and 64-bit data; index 0 threshold, 1 stride,
// 2 and 3 the preset anchors. Write only while the block is idle.
// The front end takes an item whenever the job queue has room, tests
// the score and works out the shifted anchor; dropped items leave no trace downstream.
// The back end runs one job at a time on a single shared 19x19 multiplier:
// a box goes through pop, exp lookup, five multiply steps and output load;
// a landmark skips the multiply steps for the half width and half height.
// The next job is popped only once the back end has left its output-load step.
// A stalled receiver holds the output register; the back end waits in its last
// step and the queue of two jobs then fills before input ready drops.
// Reset clears the queue, the held box and the output valid, and loads the
// register defaults.
// Depends on abld_pkg, abld_front, abld_queue and abld_back.
module anchor_box_landmark_decode_core #(
  parameter int unsigned ANCHOR_COUNT    = abld_pkg::ANCHOR_COUNT_DEF,
  parameter int unsigned GRID_BITS       = abld_pkg::GRID_BITS_DEF,
  parameter int unsigned EXP_TABLE_DEPTH = abld_pkg::EXP_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [abld_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [abld_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // func
  input  logic                              s_axis_tuser,
  // grid_col, grid_row, anchor_sel, score_in, delta_first..delta_fourth, pad
  input  logic [abld_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_kind
  output logic                              m_axis_tuser,
  // out_col, out_row, out_anchor, out_score, coord_x_a, coord_y_a, coord_x_b, coord_y_b, pad
  output logic [abld_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  logic           push, full, pop, empty;
  abld_pkg::job_t job_in, job_out;

  abld_front #(
    .ANCHOR_COUNT (ANCHOR_COUNT),
    .GRID_BITS    (GRID_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .q_full_i   (full),
    .push_o     (push),
    .job_o      (job_in)
  );

  abld_queue #(
    .DEPTH (abld_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (job_out)
  );

  abld_back #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (empty),
    .job_i      (job_out),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tuser_o  (m_axis_tuser),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

// ----- design/abld_checker.sv -----
// Port-level checks for the decoder, bound to the top level.
// Depends on abld_pkg and anchor_box_landmark_decode_core.
module abld_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic                             m_axis_tuser,
  input logic [abld_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output payload changed while stalled");

  a_landmark_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[36:21] == '0 && m_axis_tdata[116:77] == '0)
    else $error("landmark result carries score or second corner");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[abld_pkg::OUT_DATA_W-1:117] == '0)
    else $error("output padding not zero");

endmodule

bind anchor_box_landmark_decode_core abld_checker u_abld_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tdata  (m_axis_tdata)
);
